>>> hw/rtl/djs_pkg.sv
// Shared types for the deadline job sequencer: the stored job entry and
// the control word that drives the row of sorting cells. No dependencies.
`timescale 1ns / 1ps

package djs_pkg;

   localparam int DeadlineWidth = 8;
   localparam int ProfitWidth   = 9;
   localparam int DoneWidth     = 9;
   localparam int TotalWidth    = 17;

   typedef struct packed {
      logic [ProfitWidth-1:0]   profit;
      logic [DeadlineWidth-1:0] deadline;
   } job_type;

   typedef struct packed {
      logic ins;
      logic shf;
   } cell_ctl_type;

   function automatic logic goes_before(job_type a, job_type b);
      if (a.profit != b.profit) begin
         return a.profit > b.profit;
      end
      return a.deadline < b.deadline;
   endfunction

endpackage

>>> hw/rtl/djs_cell.sv
// One cell of the sorted job row: holds one job and a valid bit.
// Depends on djs_pkg.
`timescale 1ns / 1ps

module djs_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  djs_pkg::cell_ctl_type ctl,
   input  djs_pkg::job_type     new_job,
   input  djs_pkg::job_type     left_job,
   input  logic                 left_valid,
   input  logic                 left_bef,
   input  djs_pkg::job_type     right_job,
   input  logic                 right_valid,
   output djs_pkg::job_type     own_job,
   output logic                 own_valid,
   output logic                 own_bef
);
   import djs_pkg::*;

   job_type job_ff, job_in;
   logic    valid_ff, valid_in;

   assign own_bef   = !valid_ff || goes_before(new_job, job_ff);
   assign own_job   = job_ff;
   assign own_valid = valid_ff;

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         if (left_bef) begin
            job_in   = left_job;
            valid_in = left_valid;
         end else if (own_bef) begin
            job_in   = new_job;
            valid_in = 1'b1;
         end
      end else if (ctl.shf) begin
         job_in   = right_job;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

>>> hw/rtl/djs_slots.sv
// Slot map with latest-free-slot search at or before a deadline.
// Depends on djs_pkg.
`timescale 1ns / 1ps

module djs_slots #(
   parameter int MAX_DEADLINE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                lookup,
   input  logic [djs_pkg::DeadlineWidth-1:0]   deadline,
   output logic                                hit
);
   import djs_pkg::*;

   logic [MAX_DEADLINE-1:0] taken_ff, taken_in;
   logic [MAX_DEADLINE-1:0] free_mask, pick;

   always_comb begin
      for (int i = 0; i < MAX_DEADLINE; i++) begin
         free_mask[i] = !taken_ff[i] && (32'(i) < 32'(deadline));
      end
      pick = '0;
      for (int i = 0; i < MAX_DEADLINE; i++) begin
         if (free_mask[i]) begin
            pick    = '0;
            pick[i] = 1'b1;
         end
      end
      hit = |free_mask;
      if (clear) begin
         taken_in = '0;
      end else if (lookup) begin
         taken_in = taken_ff | pick;
      end else begin
         taken_in = taken_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else begin
         taken_ff <= taken_in;
      end
   end

endmodule

>>> hw/rtl/deadline_job_sequencer.sv
// Top level of the deadline job sequencer: row of sorting cells, slot map
// and control. Depends on djs_pkg, djs_cell and djs_slots.
`timescale 1ns / 1ps

// Jobs are loaded one beat per cycle into a row of MAX_JOBS cells that keeps
// them ordered by profit, highest first, earlier deadline on ties. A beat with
// last_job starts scheduling: the row shifts one job per cycle into the slot
// map, which takes the latest free slot at or before the deadline (deadlines
// above MAX_DEADLINE act as MAX_DEADLINE). The result beat is held until
// taken, and the next set is accepted after that. Jobs arriving with the row
// full are dropped and reported through overflow.
module deadline_job_sequencer #(
   parameter int MAX_JOBS     = 256,
   parameter int MAX_DEADLINE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [djs_pkg::DeadlineWidth-1:0]   req_deadline,
   input  logic [djs_pkg::ProfitWidth-1:0]     req_profit,
   input  logic                                req_last_job,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [djs_pkg::DoneWidth-1:0]       rsp_jobs_done,
   output logic [djs_pkg::TotalWidth-1:0]      rsp_total_profit,
   output logic                                rsp_overflow
);
   import djs_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic drop_ff, drop_in;
   logic [DoneWidth-1:0]  done_ff, done_in;
   logic [TotalWidth-1:0] sum_ff, sum_in;
   logic ovf_ff, ovf_in;

   job_type      new_job;
   cell_ctl_type ctl;
   job_type      jobs  [MAX_JOBS];
   logic         valids[MAX_JOBS];
   logic         befs  [MAX_JOBS];
   logic         full, accept, hit, clear_slots, lookup;
   logic [DeadlineWidth-1:0] head_dl;
   logic [TotalWidth:0] sum_next;

   assign new_job.deadline = req_deadline;
   assign new_job.profit   = req_profit;
   assign full      = valids[MAX_JOBS-1];
   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign ctl.ins   = accept && !full;
   assign ctl.shf   = (state_ff == ST_RUN);

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      job_type lj, rj;
      logic    lv, lb, rv;
      if (g == 0) begin : g_first
         assign lj = new_job;
         assign lv = 1'b0;
         assign lb = 1'b0;
      end else begin : g_mid
         assign lj = jobs[g-1];
         assign lv = valids[g-1];
         assign lb = befs[g-1];
      end
      if (g == MAX_JOBS - 1) begin : g_end
         assign rj = new_job;
         assign rv = 1'b0;
      end else begin : g_inner
         assign rj = jobs[g+1];
         assign rv = valids[g+1];
      end
      djs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_job     (new_job),
         .left_job    (lj),
         .left_valid  (lv),
         .left_bef    (lb),
         .right_job   (rj),
         .right_valid (rv),
         .own_job     (jobs[g]),
         .own_valid   (valids[g]),
         .own_bef     (befs[g])
      );
   end

   assign clear_slots = accept && req_last_job;
   assign lookup      = (state_ff == ST_RUN) && valids[0];
   assign head_dl     = jobs[0].deadline;

   djs_slots #(.MAX_DEADLINE(MAX_DEADLINE)) u_slots (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear_slots),
      .lookup   (lookup),
      .deadline (head_dl),
      .hit      (hit)
   );

   assign sum_next = {1'b0, sum_ff} + (TotalWidth+1)'(jobs[0].profit);

   always_comb begin
      state_in = state_ff;
      drop_in  = drop_ff;
      done_in  = done_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end
               if (req_last_job) begin
                  done_in  = '0;
                  sum_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (valids[0]) begin
               if (hit) begin
                  if (done_ff != '1) begin
                     done_in = done_ff + 1'b1;
                  end
                  sum_in = sum_next[TotalWidth] ? '1 : sum_next[TotalWidth-1:0];
               end
            end else begin
               ovf_in   = drop_ff;
               drop_in  = 1'b0;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         drop_ff  <= drop_in;
      end
      done_ff <= done_in;
      sum_ff  <= sum_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid        = (state_ff == ST_HOLD);
   assign rsp_jobs_done    = done_ff;
   assign rsp_total_profit = sum_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

>>> test/tb_deadline_job_sequencer.sv
// Self-checking bench for deadline_job_sequencer: drives job sets, predicts
// the greedy schedule per set and compares each result beat. Depends on djs_pkg.
`timescale 1ns / 1ps

class schedule_board;
   int unsigned max_jobs;
   int unsigned max_deadline;
   djs_pkg::job_type jobs[$];
   bit dropped;
   logic [26:0] pending[$];
   int errors;

   function new(int unsigned mj, int unsigned md);
      max_jobs = mj;
      max_deadline = md;
      dropped = 0;
      errors = 0;
   endfunction

   function void note_job(logic [7:0] d, logic [8:0] p, logic last);
      djs_pkg::job_type e;
      int pos;
      bit taken[];
      int unsigned n, sum, dd;
      e.deadline = d;
      e.profit = p;
      if (jobs.size() < max_jobs) begin
         pos = jobs.size();
         for (int i = 0; i < jobs.size(); i++) begin
            if (e.profit > jobs[i].profit ||
                (e.profit == jobs[i].profit && e.deadline < jobs[i].deadline)) begin
               pos = i;
               break;
            end
         end
         jobs.insert(pos, e);
      end else begin
         dropped = 1;
      end
      if (!last) return;
      taken = new[max_deadline + 1];
      n = 0;
      sum = 0;
      foreach (jobs[i]) begin
         dd = jobs[i].deadline;
         if (dd > max_deadline) dd = max_deadline;
         for (int s = dd; s >= 1; s--) begin
            if (!taken[s]) begin
               taken[s] = 1;
               if (n < 511) n++;
               sum += jobs[i].profit;
               if (sum > 131071) sum = 131071;
               break;
            end
         end
      end
      pending.push_back({n[8:0], sum[16:0], dropped});
      jobs.delete();
      dropped = 0;
   endfunction

   task check_result(logic [8:0] done, logic [16:0] total, logic ovf);
      logic [26:0] exp_word;
      if (pending.size() == 0) begin
         report_error($sformatf("unexpected beat %0d %0d %0d", done, total, ovf));
         return;
      end
      exp_word = pending.pop_front();
      if (done !== exp_word[26:18])
         report_error($sformatf("jobs_done %0d, want %0d", done, exp_word[26:18]));
      if (total !== exp_word[17:1])
         report_error($sformatf("total_profit %0d, want %0d", total, exp_word[17:1]));
      if (ovf !== exp_word[0])
         report_error($sformatf("overflow %0d, want %0d", ovf, exp_word[0]));
   endtask

   task report_error(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask
endclass

module tb_deadline_job_sequencer;
   localparam int MaxJobs = 256;
   localparam int MaxDeadline = 128;
   localparam longint CycleLimit = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_deadline = 0;
   logic [8:0] req_profit = 0;
   logic req_last_job = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [8:0] rsp_jobs_done;
   logic [16:0] rsp_total_profit;
   logic rsp_overflow;

   schedule_board board = new(MaxJobs, MaxDeadline);
   int send_idle = 37;
   int recv_idle = 56;
   longint cycles = 0;

   deadline_job_sequencer #(.MAX_JOBS(MaxJobs), .MAX_DEADLINE(MaxDeadline)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_deadline(req_deadline), .req_profit(req_profit),
      .req_last_job(req_last_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_jobs_done(rsp_jobs_done), .rsp_total_profit(rsp_total_profit),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_deadline_job_sequencer: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_jobs_done, rsp_total_profit, rsp_overflow);
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_job(logic [7:0] d, logic [8:0] p, logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_deadline <= d;
      req_profit <= p;
      req_last_job <= last;
      do @(posedge clock); while (!req_ready);
      board.note_job(d, p, last);
   endtask

   task automatic send_set(int n, int dmax);
      for (int i = 0; i < n; i++)
         send_job(8'($urandom_range(dmax)), 9'($urandom_range(511)), i == n - 1);
   endtask

   initial begin
      int n;
      int k;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, zero and oversize deadlines, ties, single jobs
      send_job(8'd1, 9'd0, 1);
      send_job(8'd255, 9'd511, 1);
      send_job(8'd0, 9'd300, 1);
      send_job(8'd2, 9'd100, 0);
      send_job(8'd1, 9'd100, 0);
      send_job(8'd1, 9'd100, 0);
      send_job(8'd128, 9'd511, 0);
      send_job(8'd129, 9'd1, 0);
      send_job(8'd0, 9'd5, 0);
      send_job(8'd170, 9'd170, 0);
      send_job(8'd85, 9'd341, 1);
      // fill past capacity, drop with last_job on a full store
      for (int i = 0; i < MaxJobs + 3; i++)
         send_job(8'($urandom_range(255)), 9'($urandom_range(511)), i == MaxJobs + 2);
      for (int i = 0; i < MaxJobs; i++)
         send_job(8'd200, 9'd511, i == MaxJobs - 1);
      k = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 37 : (phase == 1) ? 56 : 0;
         recv_idle = (phase == 0) ? 56 : (phase == 1) ? 37 : 0;
         k = 0;
         while (k < 125) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40) + 1 : $urandom_range(8) + 1;
            send_set(n, ($urandom_range(3) == 0) ? 255 : 12);
            k += n;
         end
      end
      req_valid <= 0;
      n = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (board.errors == 0)
         $display("tb_deadline_job_sequencer: clean");
      else
         $display("tb_deadline_job_sequencer: errors");
      $finish;
   end
endmodule

>>> files.f
hw/rtl/djs_pkg.sv
hw/rtl/djs_cell.sv
hw/rtl/djs_slots.sv
hw/rtl/deadline_job_sequencer.sv
test/tb_deadline_job_sequencer.sv
